FILE: hdl/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types, codes and constants shared by the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

    // operation codes of the input item
    typedef enum logic [3:0] {
        OP_INIT     = 4'd0,
        OP_CLEAR    = 4'd1,
        OP_HOME     = 4'd2,
        OP_ENTRY    = 4'd3,
        OP_DISPLAY  = 4'd4,
        OP_SHIFT    = 4'd5,
        OP_FUNCTION = 4'd6,
        OP_ADDRESS  = 4'd7,
        OP_CHAR     = 4'd8,
        OP_RAW      = 4'd9
    } t_opcode;

    // configuration register indexes
    localparam logic [1:0] CFG_STROBE = 2'd0;
    localparam logic [1:0] CFG_BYTE   = 2'd1;
    localparam logic [1:0] CFG_CHAR   = 2'd2;
    localparam logic [1:0] CFG_INIT   = 2'd3;

    // configuration reset values
    localparam logic [7:0] STROBE_RST = 8'd1;
    localparam logic [7:0] BYTE_RST   = 8'd10;
    localparam logic [7:0] CHAR_RST   = 8'd2;
    localparam logic [7:0] INIT_RST   = 8'd20;

    // command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'b0000_0001;
    localparam logic [7:0] CMD_HOME     = 8'b0000_0010;
    localparam logic [7:0] CMD_ENTRY    = 8'b0000_0100;
    localparam logic [7:0] CMD_DISPLAY  = 8'b0000_1000;
    localparam logic [7:0] CMD_SHIFT    = 8'b0001_0000;
    localparam logic [7:0] CMD_FUNCTION = 8'b0010_0000;
    localparam logic [7:0] CMD_ADDRESS  = 8'b1000_0000;
    localparam logic [6:0] ADDR_MASK    = 7'b111_1111;
    localparam logic [6:0] ROW1_OFFSET  = 7'd40;

    // init sequence: four single nibbles then five bytes
    localparam logic [3:0] INIT_LAST_NIB = 4'd13;

    // extra wait added to the final phase of a nibble
    typedef enum logic [2:0] {
        GAP_NONE      = 3'd0,
        GAP_INIT      = 3'd1,
        GAP_BYTE      = 3'd2,
        GAP_BYTE_INIT = 3'd3,
        GAP_BYTE_CHAR = 3'd4
    } t_gap;

    // one queued operation after decode
    typedef struct packed {
        logic       is_init;
        logic [7:0] value;
        logic       rs;
        logic       add_char;
    } t_job;

    // what one nibble sends and waits
    typedef struct packed {
        logic [3:0] nib;
        t_gap       gap;
    } t_nib_plan;

    // configuration write port
    typedef struct packed {
        logic       we;
        logic [1:0] idx;
        logic [7:0] data;
    } t_cfg_wr;

    // nibble plan of the power-up init sequence
    function automatic t_nib_plan init_plan(input logic [3:0] idx);
        t_nib_plan p;
        case (idx)
            4'd0, 4'd1, 4'd2: p = '{nib: 4'h3, gap: GAP_INIT};
            4'd3:             p = '{nib: 4'h2, gap: GAP_NONE};
            4'd4:             p = '{nib: 4'h2, gap: GAP_BYTE};
            4'd5:             p = '{nib: 4'h8, gap: GAP_BYTE_INIT};
            4'd6:             p = '{nib: 4'h0, gap: GAP_BYTE};
            4'd7:             p = '{nib: 4'h8, gap: GAP_BYTE_INIT};
            4'd8:             p = '{nib: 4'h0, gap: GAP_BYTE};
            4'd9:             p = '{nib: 4'h1, gap: GAP_BYTE_INIT};
            4'd10:            p = '{nib: 4'h0, gap: GAP_BYTE};
            4'd11:            p = '{nib: 4'h6, gap: GAP_BYTE_INIT};
            4'd12:            p = '{nib: 4'h0, gap: GAP_BYTE};
            4'd13:            p = '{nib: 4'hF, gap: GAP_BYTE_INIT};
            default:          p = '{nib: 4'h0, gap: GAP_NONE};
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/lcd4_op_if.sv
// ----------------------------------------------------------------------------
// lcd4_op_if
// Operation channel: valid, ready and the fields of one operation.
// ----------------------------------------------------------------------------
interface lcd4_op_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic       flag_a;
    logic       flag_b;
    logic       flag_c;
    logic [6:0] address;
    logic       row;
    logic [7:0] byte_value;
    logic       reg_select;

    modport source (
        output valid, opcode, flag_a, flag_b, flag_c, address, row, byte_value,
               reg_select,
        input  ready
    );
    modport sink (
        input  valid, opcode, flag_a, flag_b, flag_c, address, row, byte_value,
               reg_select,
        output ready
    );
endinterface

FILE: hdl/lcd4_step_if.sv
// ----------------------------------------------------------------------------
// lcd4_step_if
// Step channel: valid, ready and one timed pin state of the LCD bus.
// ----------------------------------------------------------------------------
interface lcd4_step_if;
    logic       valid;
    logic       ready;
    logic       rs_level;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [9:0] hold_ms;
    logic       last_step;

    modport source (
        output valid, rs_level, data_nibble, enable_level, hold_ms, last_step,
        input  ready
    );
    modport sink (
        input  valid, rs_level, data_nibble, enable_level, hold_ms, last_step,
        output ready
    );
endinterface

FILE: hdl/char_lcd_4bit_interface_sequencer_core.sv
// Path: an operation is written into the queue, popped by the idle sequencer,
// and its first pin step is registered at the output. Throughput: one step per
// cycle while the step sink is not stalling; a byte operation is one load plus 6
// steps, init one load plus 42 steps. Unknown opcodes are taken, make no step.
// Reset: delay registers return to 1/10/2/20 ms, queue and sequencer empty.
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_sequencer_core
// 4-bit character LCD sequencer: operations in, timed pin steps out.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_sequencer_core
    import lcd4_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    lcd4_op_if.sink     i_op,
    lcd4_step_if.source o_step
);

    t_cfg_wr cfg;
    logic    q_push;
    t_job    q_in_job;
    logic    q_full;
    logic    q_valid;
    t_job    q_out_job;
    logic    q_pop;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    // decode and classify
    lcd4_front u_front (
        .i_op   (i_op),
        .i_full (q_full),
        .o_push (q_push),
        .o_job  (q_in_job)
    );

    // decoupling queue
    lcd4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job),
        .i_pop   (q_pop)
    );

    // step sequencer
    lcd4_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .o_step      (o_step)
    );

endmodule

FILE: hdl/lcd4_front.sv
// ----------------------------------------------------------------------------
// lcd4_front
// Accepts operations, builds the command byte and drops unknown opcodes.
// ----------------------------------------------------------------------------
module lcd4_front
    import lcd4_pkg::*;
(
    lcd4_op_if.sink i_op,
    input  logic    i_full,
    output logic    o_push,
    output t_job    o_job
);

    logic [6:0] addr_sum;
    logic       known;

    // take a transfer whenever the queue has room
    assign i_op.ready = !i_full;

    // row 1 offset, wraps in 7 bits
    assign addr_sum = (i_op.address + (i_op.row ? ROW1_OFFSET : 7'd0)) & ADDR_MASK;

    // classify the operation
    always_comb begin
        known          = 1'b1;
        o_job.is_init  = 1'b0;
        o_job.value    = 8'd0;
        o_job.rs       = 1'b0;
        o_job.add_char = 1'b0;
        case (t_opcode'(i_op.opcode))
            OP_INIT: begin
                o_job.is_init = 1'b1;
            end
            OP_CLEAR:    o_job.value = CMD_CLEAR;
            OP_HOME:     o_job.value = CMD_HOME;
            OP_ENTRY:    o_job.value = CMD_ENTRY | {6'd0, i_op.flag_a, i_op.flag_b};
            OP_DISPLAY: begin
                o_job.value = CMD_DISPLAY | {5'd0, i_op.flag_a, i_op.flag_b, i_op.flag_c};
            end
            OP_SHIFT: begin
                o_job.value = CMD_SHIFT | {4'd0, i_op.flag_a, i_op.flag_b, 2'd0};
            end
            OP_FUNCTION: begin
                o_job.value = CMD_FUNCTION |
                              {3'd0, i_op.flag_a, i_op.flag_b, i_op.flag_c, 2'd0};
            end
            OP_ADDRESS:  o_job.value = CMD_ADDRESS | {1'b0, addr_sum};
            OP_CHAR: begin
                o_job.value    = i_op.byte_value;
                o_job.rs       = 1'b1;
                o_job.add_char = 1'b1;
            end
            OP_RAW: begin
                o_job.value = i_op.byte_value;
                o_job.rs    = i_op.reg_select;
            end
            default: known = 1'b0;
        endcase
    end

    assign o_push = i_op.valid && !i_full && known;

endmodule

FILE: hdl/lcd4_queue.sv
// ----------------------------------------------------------------------------
// lcd4_queue
// Small FIFO of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module lcd4_queue
    import lcd4_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("lcd4_queue: push while full");

endmodule

FILE: hdl/lcd4_back.sv
// ----------------------------------------------------------------------------
// lcd4_back
// Walks each queued operation nibble by nibble and phase by phase, one timed
// pin step per unstalled cycle to the output register; holds delay registers.
// ----------------------------------------------------------------------------
module lcd4_back
    import lcd4_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg_wr      i_cfg,
    input  logic         i_job_valid,
    input  t_job         i_job,
    output logic         o_job_pop,
    lcd4_step_if.source  o_step
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;

    t_state     r_state, n_state;
    t_job       r_job;
    logic [3:0] r_nib, n_nib;
    logic [1:0] r_phase, n_phase;

    logic [7:0] r_strobe, r_byte_gap, r_char_gap, r_init_gap;

    logic       r_out_valid;
    logic       r_out_rs;
    logic [3:0] r_out_nib;
    logic       r_out_en;
    logic [9:0] r_out_hold;
    logic       r_out_last;

    t_nib_plan  plan;
    logic [8:0] extra;
    logic [9:0] hold;
    logic       step_last;
    logic       emit;

    // delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= STROBE_RST;
            r_byte_gap <= BYTE_RST;
            r_char_gap <= CHAR_RST;
            r_init_gap <= INIT_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_STROBE: r_strobe   <= i_cfg.data;
                CFG_BYTE:   r_byte_gap <= i_cfg.data;
                CFG_CHAR:   r_char_gap <= i_cfg.data;
                CFG_INIT:   r_init_gap <= i_cfg.data;
                default:    r_strobe   <= r_strobe;
            endcase
        end
    end

    // nibble to send and the wait after it
    always_comb begin
        if (r_job.is_init) begin
            plan = init_plan(r_nib);
        end else begin
            plan.nib = r_nib[0] ? r_job.value[3:0] : r_job.value[7:4];
            if (!r_nib[0]) begin
                plan.gap = GAP_BYTE;
            end else if (r_job.add_char) begin
                plan.gap = GAP_BYTE_CHAR;
            end else begin
                plan.gap = GAP_BYTE;
            end
        end
    end

    always_comb begin
        case (plan.gap)
            GAP_INIT:      extra = {1'b0, r_init_gap};
            GAP_BYTE:      extra = {1'b0, r_byte_gap};
            GAP_BYTE_INIT: extra = {1'b0, r_byte_gap} + {1'b0, r_init_gap};
            GAP_BYTE_CHAR: extra = {1'b0, r_byte_gap} + {1'b0, r_char_gap};
            default:       extra = 9'd0;
        endcase
    end

    assign hold      = {2'b00, r_strobe} + ((r_phase == PH_LOW) ? {1'b0, extra} : 10'd0);
    assign step_last = (r_phase == PH_LOW) &&
                       (r_job.is_init ? (r_nib == INIT_LAST_NIB) : r_nib[0]);
    assign emit      = (r_state == ST_RUN) && (!r_out_valid || o_step.ready);
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_nib   = r_nib;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = ST_RUN;
                    n_nib   = 4'd0;
                    n_phase = PH_SETUP;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (step_last) begin
                        n_state = ST_IDLE;
                    end else if (r_phase == PH_LOW) begin
                        n_phase = PH_SETUP;
                        n_nib   = r_nib + 4'd1;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nib   <= 4'd0;
            r_phase <= PH_SETUP;
        end else begin
            r_state <= n_state;
            r_nib   <= n_nib;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_step.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_rs   <= r_job.rs;
            r_out_nib  <= plan.nib;
            r_out_en   <= (r_phase == PH_HIGH);
            r_out_hold <= hold;
            r_out_last <= step_last;
        end
    end

    assign o_step.valid        = r_out_valid;
    assign o_step.rs_level     = r_out_rs;
    assign o_step.data_nibble  = r_out_nib;
    assign o_step.enable_level = r_out_en;
    assign o_step.hold_ms      = r_out_hold;
    assign o_step.last_step    = r_out_last;

    // a byte operation stays within its two nibbles
    a_byte_nibbles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !r_job.is_init) |-> (r_nib <= 4'd1))
        else $error("lcd4_back: byte job beyond low nibble");

    // the final step ends the operation
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && step_last) |=> (r_state == ST_IDLE))
        else $error("lcd4_back: still running after final step");

    // phase never leaves the three nibble phases
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_phase != 2'd3))
        else $error("lcd4_back: bad nibble phase");

endmodule

FILE: verif/tb_char_lcd_4bit_interface_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_4bit_interface_sequencer_core
// Drives LCD operations into the sequencer and predicts every timed pin step
// it should emit (three phases per nibble, high nibble first). Each step is
// checked field by field in order. Runs directed operations, the delay
// registers at their extremes and random traffic with gaps and stalls.
// ----------------------------------------------------------------------------
module tb_char_lcd_4bit_interface_sequencer_core;
    import lcd4_pkg::*;

    // opcodes with no operation behind them
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    // power-up nibbles: wake-up and switch to 4-bit mode
    localparam logic [3:0] WAKE_NIB     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB = 4'h2;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [3:0] opcode;
        logic       flag_a;
        logic       flag_b;
        logic       flag_c;
        logic [6:0] address;
        logic       row;
        logic [7:0] byte_value;
        logic       reg_select;
    } t_lcd_op;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       en;
        logic [9:0] hold;
        logic       last;
    } t_pin_step;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    lcd4_op_if   op_ch();
    lcd4_step_if step_ch();

    char_lcd_4bit_interface_sequencer_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_op      (op_ch),
        .o_step    (step_ch)
    );

    // local copy of the delay registers
    logic [7:0] strobe_ms = STROBE_RST;
    logic [7:0] byte_ms   = BYTE_RST;
    logic [7:0] char_ms   = CHAR_RST;
    logic [7:0] init_ms   = INIT_RST;

    t_pin_step pending_steps[$];
    t_pin_step op_steps[$];

    bit src_idle_en = 1'b1;
    bit snk_stall_en = 1'b1;
    int fail_count;
    int ops_sent;
    int inits_sent;
    int unused_sent;
    int steps_seen;
    int settings_used;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // three phases of one nibble, extra wait on the last one
    function automatic void queue_nibble(logic [3:0] nib, logic rs, logic [9:0] extra);
        t_pin_step s;
        s.rs   = rs;
        s.nib  = nib;
        s.last = 1'b0;
        s.hold = {2'b00, strobe_ms};
        s.en   = 1'b0;
        op_steps.push_back(s);
        s.en   = 1'b1;
        op_steps.push_back(s);
        s.en   = 1'b0;
        s.hold = {2'b00, strobe_ms} + extra;
        op_steps.push_back(s);
    endfunction

    function automatic void queue_byte(logic [7:0] value, logic rs, logic [9:0] extra);
        queue_nibble(value[7:4], rs, {2'b00, byte_ms});
        queue_nibble(value[3:0], rs, {2'b00, byte_ms} + extra);
    endfunction

    // pin steps that one operation should produce
    function automatic void plan_steps(t_lcd_op op);
        t_pin_step  tail;
        logic [6:0] ddram;
        logic [9:0] init_gap;
        op_steps.delete();
        init_gap = {2'b00, init_ms};
        ddram = op.address + (op.row ? ROW1_OFFSET : 7'd0);
        case (op.opcode)
            OP_INIT: begin
                queue_nibble(WAKE_NIB, 1'b0, init_gap);
                queue_nibble(WAKE_NIB, 1'b0, init_gap);
                queue_nibble(WAKE_NIB, 1'b0, init_gap);
                queue_nibble(FOUR_BIT_NIB, 1'b0, 10'd0);
                // 4-bit, two lines; display off; clear; increment; all on
                queue_byte(CMD_FUNCTION | 8'h08, 1'b0, init_gap);
                queue_byte(CMD_DISPLAY, 1'b0, init_gap);
                queue_byte(CMD_CLEAR, 1'b0, init_gap);
                queue_byte(CMD_ENTRY | 8'h02, 1'b0, init_gap);
                queue_byte(CMD_DISPLAY | 8'h07, 1'b0, init_gap);
            end
            OP_CLEAR:    queue_byte(CMD_CLEAR, 1'b0, 10'd0);
            OP_HOME:     queue_byte(CMD_HOME, 1'b0, 10'd0);
            OP_ENTRY:
                queue_byte(CMD_ENTRY | {6'b0, op.flag_a, op.flag_b}, 1'b0, 10'd0);
            OP_DISPLAY:
                queue_byte(CMD_DISPLAY | {5'b0, op.flag_a, op.flag_b, op.flag_c},
                           1'b0, 10'd0);
            OP_SHIFT:
                queue_byte(CMD_SHIFT | {4'b0, op.flag_a, op.flag_b, 2'b00}, 1'b0, 10'd0);
            OP_FUNCTION:
                queue_byte(CMD_FUNCTION | {3'b0, op.flag_a, op.flag_b, op.flag_c, 2'b00},
                           1'b0, 10'd0);
            OP_ADDRESS:  queue_byte(CMD_ADDRESS | {1'b0, ddram}, 1'b0, 10'd0);
            OP_CHAR:     queue_byte(op.byte_value, 1'b1, {2'b00, char_ms});
            OP_RAW:      queue_byte(op.byte_value, op.reg_select, 10'd0);
            default: ;
        endcase
        if (op_steps.size() > 0) begin
            tail = op_steps.pop_back();
            tail.last = 1'b1;
            op_steps.push_back(tail);
        end
        foreach (op_steps[k])
            pending_steps.push_back(op_steps[k]);
    endfunction

    function automatic t_lcd_op rand_op();
        t_lcd_op op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            op.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (r < 10)
            op.opcode = OP_INIT;
        else
            op.opcode = 4'($urandom_range(OP_CLEAR, OP_RAW));
        op.flag_a     = 1'($urandom_range(0, 1));
        op.flag_b     = 1'($urandom_range(0, 1));
        op.flag_c     = 1'($urandom_range(0, 1));
        op.address    = 7'($urandom_range(0, 127));
        op.row        = 1'($urandom_range(0, 1));
        op.byte_value = 8'($urandom_range(0, 255));
        op.reg_select = 1'($urandom_range(0, 1));
        return op;
    endfunction

    // one operation transfer; called and returns at a falling edge
    task automatic send_op(t_lcd_op op);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            op_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        op_ch.valid      = 1'b1;
        op_ch.opcode     = op.opcode;
        op_ch.flag_a     = op.flag_a;
        op_ch.flag_b     = op.flag_b;
        op_ch.flag_c     = op.flag_c;
        op_ch.address    = op.address;
        op_ch.row        = op.row;
        op_ch.byte_value = op.byte_value;
        op_ch.reg_select = op.reg_select;
        do @(posedge i_clk); while (!op_ch.ready);
        plan_steps(op);
        ops_sent++;
        if (op.opcode == OP_INIT) inits_sent++;
        if (op.opcode >= OP_UNUSED_LO) unused_sent++;
        @(negedge i_clk);
        op_ch.valid = 1'b0;
    endtask

    task automatic send_kind(logic [3:0] opcode);
        t_lcd_op op;
        op = rand_op();
        op.opcode = opcode;
        send_op(op);
    endtask

    // wait until every predicted step is out, then let the block settle
    task automatic drain();
        while (pending_steps.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_STROBE: strobe_ms = value;
            CFG_BYTE:   byte_ms   = value;
            CFG_CHAR:   char_ms   = value;
            CFG_INIT:   init_ms   = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [7:0] s, logic [7:0] b, logic [7:0] c,
                                 logic [7:0] n);
        drain();
        write_reg(CFG_STROBE, s);
        write_reg(CFG_BYTE, b);
        write_reg(CFG_CHAR, c);
        write_reg(CFG_INIT, n);
        settings_used++;
    endtask

    // every operation at least once, flag corners, address wrap, unused opcodes
    task automatic test_directed_ops();
        t_lcd_op op;
        send_kind(OP_INIT);
        send_kind(OP_CLEAR);
        send_kind(OP_HOME);
        op = rand_op(); op.opcode = OP_ENTRY;
        op.flag_a = 1'b1; op.flag_b = 1'b0; send_op(op);
        op.flag_a = 1'b0; op.flag_b = 1'b1; send_op(op);
        op = rand_op(); op.opcode = OP_DISPLAY;
        {op.flag_a, op.flag_b, op.flag_c} = 3'b111; send_op(op);
        {op.flag_a, op.flag_b, op.flag_c} = 3'b000; send_op(op);
        op = rand_op(); op.opcode = OP_SHIFT;
        {op.flag_a, op.flag_b, op.flag_c} = 3'b101; send_op(op);
        {op.flag_a, op.flag_b, op.flag_c} = 3'b010; send_op(op);
        op = rand_op(); op.opcode = OP_FUNCTION;
        {op.flag_a, op.flag_b, op.flag_c} = 3'b111; send_op(op);
        {op.flag_a, op.flag_b, op.flag_c} = 3'b000; send_op(op);
        // address with row offset, including wrap past 127
        op = rand_op(); op.opcode = OP_ADDRESS;
        op.address = 7'd0;   op.row = 1'b0; send_op(op);
        op.address = 7'd127; op.row = 1'b1; send_op(op);
        op.address = 7'd88;  op.row = 1'b1; send_op(op);
        op.address = 7'd127; op.row = 1'b0; send_op(op);
        op = rand_op(); op.opcode = OP_CHAR;
        op.byte_value = 8'hFF; send_op(op);
        op.byte_value = 8'h00; send_op(op);
        op = rand_op(); op.opcode = OP_RAW;
        op.byte_value = 8'hA5; op.reg_select = 1'b1; send_op(op);
        op.byte_value = 8'h5A; op.reg_select = 1'b0; send_op(op);
        send_kind(OP_UNUSED_LO);
        send_kind(OP_UNUSED_HI);
    endtask

    // delay registers at their extremes and at random values
    task automatic test_register_extremes();
        apply_setting(8'd0, 8'd0, 8'd0, 8'd0);
        repeat (35) send_op(rand_op());
        apply_setting(8'd255, 8'd255, 8'd255, 8'd255);
        repeat (35) send_op(rand_op());
        apply_setting(8'd255, 8'd0, 8'd255, 8'd0);
        repeat (35) send_op(rand_op());
        apply_setting(8'd0, 8'd255, 8'd0, 8'd255);
        repeat (35) send_op(rand_op());
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (35) send_op(rand_op());
    endtask

    // random operations at reset delays, then a stretch at full rate
    task automatic test_random_traffic();
        apply_setting(STROBE_RST, BYTE_RST, CHAR_RST, INIT_RST);
        repeat (200) send_op(rand_op());
        src_idle_en  = 1'b0;
        snk_stall_en = 1'b0;
        repeat (65) send_op(rand_op());
        src_idle_en  = 1'b1;
        snk_stall_en = 1'b1;
    endtask

    // step sink: random stalls
    initial begin : step_sink
        int stall_left;
        stall_left = 0;
        step_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                step_ch.ready = 1'b0;
            end else if (snk_stall_en && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
                step_ch.ready = 1'b0;
            end else begin
                step_ch.ready = 1'b1;
            end
        end
    end

    // compare each step transfer with the oldest prediction
    initial begin : step_checker
        t_pin_step got;
        t_pin_step want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && step_ch.valid && step_ch.ready) begin
                got = {step_ch.rs_level, step_ch.data_nibble, step_ch.enable_level,
                       step_ch.hold_ms, step_ch.last_step};
                steps_seen++;
                if (pending_steps.size() == 0) begin
                    note_fail($sformatf("unexpected step rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                              got.rs, got.nib, got.en, got.hold, got.last));
                end else begin
                    want = pending_steps.pop_front();
                    if (got != want)
                        note_fail($sformatf({"exp rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                             " got rs=%0d nib=%h en=%0d hold=%0d last=%0d"},
                                  want.rs, want.nib, want.en, want.hold, want.last,
                                  got.rs, got.nib, got.en, got.hold, got.last));
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((op_ch.valid && op_ch.ready) || (step_ch.valid && step_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d steps outstanding",
                         quiet, pending_steps.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : main_seq
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_STROBE;
        i_cfg_data = 8'd0;
        op_ch.valid      = 1'b0;
        op_ch.opcode     = OP_INIT;
        op_ch.flag_a     = 1'b0;
        op_ch.flag_b     = 1'b0;
        op_ch.flag_c     = 1'b0;
        op_ch.address    = 7'd0;
        op_ch.row        = 1'b0;
        op_ch.byte_value = 8'd0;
        op_ch.reg_select = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_register_extremes();
        test_random_traffic();

        drain();
        repeat (20) @(posedge i_clk);
        if (pending_steps.size() != 0)
            note_fail($sformatf("%0d predicted steps never arrived", pending_steps.size()));

        $display("ran %0d operations (%0d init, %0d unused opcodes), checked %0d pin steps",
                 ops_sent, inits_sent, unused_sent, steps_seen);
        $display("delay register settings applied: %0d, failures: %0d",
                 settings_used, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
